// ----- sv/lru_page_buffer_pool_top_defines.svh -----
// Assertion macros shared by the buffer pool modules.
// No dependencies.
`ifndef LRU_PAGE_BUFFER_POOL_TOP_DEFINES_SVH
`define LRU_PAGE_BUFFER_POOL_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define LPB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define LPB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lpbp_pkg.sv -----
// Types, codes and constants for the LRU page buffer pool.
// No dependencies.
`timescale 1ns / 1ps
package lpbp_pkg;
  localparam int unsigned POOL_FRAMES_DEF = 32;
  localparam int unsigned PAGE_BITS_DEF   = 20;
  localparam int unsigned FILE_BITS_DEF   = 8;
  localparam int unsigned MAX_RESULTS     = 32;
  localparam logic [7:0]  PIN_MAX         = 8'd255;

  localparam logic [2:0] REQ_FETCH = 3'd0;
  localparam logic [2:0] REQ_PIN   = 3'd1;
  localparam logic [2:0] REQ_UNPIN = 3'd2;
  localparam logic [2:0] REQ_DIRTY = 3'd3;
  localparam logic [2:0] REQ_FLUSH = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_RES  = 2'd1;
  localparam logic [1:0] ST_UNPINNED = 2'd2;
  localparam logic [1:0] ST_NO_FRAME = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  file_id;
    logic [19:0] page_num;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  frame_index;
    logic        hit;
    logic        writeback_valid;
    logic [7:0]  writeback_file;
    logic [19:0] writeback_page;
    logic        load_valid;
    logic        last;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;       // capture request, clear scan pointer
    logic tag_step;    // compare frame at scan pointer against request tag
    logic vic_step;    // examine LRU position at scan pointer for a free frame
    logic mru_step;    // shift LRU list one position toward the front
    logic apply_op;    // apply single-page operation and emit its result
    logic flush_step;  // examine frame at scan pointer for writeback
    logic flush_end;   // emit the held writeback as last, or the empty flush result
    logic drop_step;   // drop unpinned clean frame of the file
    logic ptr_clr;     // reset scan pointer
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ptr_last;    // scan pointer at last frame
    logic found;       // tag search found a match
    logic vic_found;   // victim found
    logic is_fetch;
    logic is_page_op;
    logic is_flush;
    logic is_clear;
    logic mru_done;    // LRU move finished
  } sts_t;
endpackage

// ----- sv/lpbp_ctrl.sv -----
// Controller state machine for the LRU page buffer pool.
// Depends on lpbp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lru_page_buffer_pool_top_defines.svh"
module lpbp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lpbp_pkg::sts_t  sts,
  output lpbp_pkg::cmd_t  cmd
);
  import lpbp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DEC   = 8'b00000010,
    S_TAG   = 8'b00000100,
    S_VIC   = 8'b00001000,
    S_MRU   = 8'b00010000,
    S_FLUSH = 8'b00100000,
    S_FEND  = 8'b01000000,
    S_DROP  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_fetch || sts.is_page_op) begin
          state_nxt = S_TAG;
        end else if (sts.is_flush || sts.is_clear) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.apply_op = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TAG: begin
        // The search ends at the first match or after the last frame.
        cmd.tag_step = 1'b1;
        if (sts.found || sts.ptr_last) begin
          cmd.ptr_clr = 1'b1;
          if (sts.is_fetch && !sts.found) begin
            state_nxt = S_VIC;
          end else begin
            cmd.apply_op = 1'b1;
            state_nxt = (sts.is_fetch) ? S_MRU : S_IDLE;
          end
        end
      end
      S_VIC: begin
        cmd.vic_step = 1'b1;
        if (sts.vic_found || sts.ptr_last) begin
          cmd.ptr_clr = 1'b1;
          cmd.apply_op = 1'b1;
          state_nxt = (sts.vic_found) ? S_MRU : S_IDLE;
        end
      end
      S_MRU: begin
        cmd.mru_step = 1'b1;
        if (sts.mru_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        cmd.flush_step = 1'b1;
        if (sts.ptr_last) begin
          cmd.ptr_clr = 1'b1;
          state_nxt = S_FEND;
        end
      end
      S_FEND: begin
        // The writeback still held is known to be the last one only here.
        cmd.flush_end = 1'b1;
        state_nxt = (sts.is_clear) ? S_DROP : S_IDLE;
      end
      S_DROP: begin
        cmd.drop_step = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `LPB_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `LPB_ASSERT_NXT(a_start, clk, rst_n, start && !busy, state_r == S_DEC, "start not taken")
  `LPB_ASSERT_IMP(a_cmd_excl, clk, rst_n, 1'b1, $onehot0({cmd.tag_step, cmd.vic_step, cmd.mru_step, cmd.flush_step, cmd.drop_step}), "overlapping scan commands")
endmodule

// ----- sv/lpbp_datapath.sv -----
// Datapath of the LRU page buffer pool: frame tables, LRU list, scan pointer.
// Depends on lpbp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lru_page_buffer_pool_top_defines.svh"
module lpbp_datapath #(
  parameter int unsigned POOL_FRAMES = lpbp_pkg::POOL_FRAMES_DEF,
  parameter int unsigned PAGE_BITS   = lpbp_pkg::PAGE_BITS_DEF,
  parameter int unsigned FILE_BITS   = lpbp_pkg::FILE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lpbp_pkg::req_t  in_req,
  input  lpbp_pkg::cmd_t  cmd,
  output lpbp_pkg::sts_t  sts,
  output logic            out_valid,
  output lpbp_pkg::rsp_t  out_rsp
);
  import lpbp_pkg::*;

  localparam int unsigned IW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_RESULTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_FRAMES - 1);

  logic [POOL_FRAMES-1:0] valid_r, dirty_r;
  logic [FILE_BITS-1:0]   file_r [POOL_FRAMES];
  logic [PAGE_BITS-1:0]   page_r [POOL_FRAMES];
  logic [7:0]             pins_r [POOL_FRAMES];
  logic [IW-1:0]          lru_r  [POOL_FRAMES];

  logic [2:0]           rq_type_r;
  logic [FILE_BITS-1:0] rq_file_r;
  logic [PAGE_BITS-1:0] rq_page_r;
  logic [IW-1:0]        ptr_r, ptr_nxt;
  logic [IW-1:0]        frm_r;     // found frame or victim
  logic [CW-1:0]        nres_r;
  logic                 mv_r;      // LRU move has located the frame
  logic                 out_valid_r, out_valid_nxt;
  rsp_t                 out_r, out_nxt;
  // A writeback is held until the next one or the end of the scan decides its last bit.
  logic                 pend_v_r;
  rsp_t                 pend_r;
  rsp_t                 wb_rsp;

  logic                 tag_hit, vic_hit;
  logic [IW-1:0]        lru_at;
  logic                 fl_hit;
  logic                 scan_step;

  assign lru_at  = lru_r[ptr_r];
  assign tag_hit = valid_r[ptr_r] && file_r[ptr_r] == rq_file_r && page_r[ptr_r] == rq_page_r;
  assign vic_hit = (pins_r[lru_at] == 8'd0);
  assign fl_hit  = valid_r[ptr_r] && file_r[ptr_r] == rq_file_r && dirty_r[ptr_r]
                   && (nres_r < CW'(MAX_RESULTS));
  assign scan_step = cmd.tag_step || cmd.vic_step || cmd.flush_step || cmd.drop_step
                     || cmd.mru_step;

  always_comb begin
    sts = '0;
    sts.ptr_last   = (ptr_r == LAST_IDX);
    sts.found      = tag_hit;
    sts.vic_found  = vic_hit;
    sts.is_fetch   = (rq_type_r == REQ_FETCH);
    sts.is_page_op = (rq_type_r == REQ_PIN) || (rq_type_r == REQ_UNPIN)
                     || (rq_type_r == REQ_DIRTY);
    sts.is_flush   = (rq_type_r == REQ_FLUSH);
    sts.is_clear   = (rq_type_r == REQ_CLEAR);
    sts.mru_done   = (ptr_r == LAST_IDX) && (mv_r || lru_at == frm_r);
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.latch || cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (scan_step) begin
      ptr_nxt = ptr_r + IW'(1);
    end
  end

  always_comb begin
    wb_rsp = '0;
    wb_rsp.frame_index     = 5'(ptr_r);
    wb_rsp.writeback_valid = 1'b1;
    wb_rsp.writeback_file  = 8'(file_r[ptr_r]);
    wb_rsp.writeback_page  = 20'(page_r[ptr_r]);
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt = '0;
    out_nxt.last = 1'b1;
    if (cmd.apply_op) begin
      out_valid_nxt = 1'b1;
      if (cmd.tag_step) begin
        if (!tag_hit) begin
          out_nxt.status = ST_NOT_RES;
        end else begin
          out_nxt.frame_index = 5'(ptr_r);
          if (rq_type_r == REQ_FETCH) begin
            out_nxt.hit = 1'b1;
          end
          if (rq_type_r == REQ_UNPIN && pins_r[ptr_r] == 8'd0) begin
            out_nxt.status = ST_UNPINNED;
          end
        end
      end else if (cmd.vic_step) begin
        if (!vic_hit) begin
          out_nxt.status = ST_NO_FRAME;
        end else begin
          out_nxt.frame_index = 5'(lru_at);
          out_nxt.load_valid  = 1'b1;
          if (valid_r[lru_at] && dirty_r[lru_at]) begin
            out_nxt.writeback_valid = 1'b1;
            out_nxt.writeback_file  = 8'(file_r[lru_at]);
            out_nxt.writeback_page  = 20'(page_r[lru_at]);
          end
        end
      end
    end else if (cmd.flush_step && fl_hit && pend_v_r) begin
      // Another writeback follows, so the held one is not the last.
      out_valid_nxt = 1'b1;
      out_nxt = pend_r;
    end else if (cmd.flush_end) begin
      out_valid_nxt = 1'b1;
      if (pend_v_r) begin
        out_nxt = pend_r;
        out_nxt.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      nres_r      <= '0;
      mv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      valid_r     <= '0;
      dirty_r     <= '0;
      for (int i = 0; i < POOL_FRAMES; i++) begin
        lru_r[i]  <= IW'(i);
        pins_r[i] <= 8'd0;
        file_r[i] <= '0;
        page_r[i] <= '0;
      end
    end else begin
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      if (cmd.latch) begin
        rq_type_r <= in_req.req_type;
        rq_file_r <= FILE_BITS'(in_req.file_id);
        rq_page_r <= PAGE_BITS'(in_req.page_num);
        nres_r    <= '0;
        mv_r      <= 1'b0;
      end
      if (cmd.tag_step && tag_hit) begin
        frm_r <= ptr_r;
      end else if (cmd.vic_step && vic_hit) begin
        frm_r <= lru_at;
      end
      if (cmd.mru_step && (mv_r || lru_at == frm_r)) begin
        // Once the frame is passed, every later entry shifts up by one.
        mv_r <= 1'b1;
        if (ptr_r != LAST_IDX) begin
          lru_r[ptr_r] <= lru_r[ptr_r + IW'(1)];
        end else begin
          lru_r[ptr_r] <= frm_r;
        end
      end
      if (cmd.flush_step && fl_hit) begin
        dirty_r[ptr_r] <= 1'b0;
        nres_r         <= nres_r + CW'(1);
        pend_r         <= wb_rsp;
        pend_v_r       <= 1'b1;
      end else if (cmd.flush_end) begin
        pend_v_r <= 1'b0;
      end
      if (cmd.drop_step && valid_r[ptr_r] && file_r[ptr_r] == rq_file_r
          && pins_r[ptr_r] == 8'd0 && !dirty_r[ptr_r]) begin
        valid_r[ptr_r] <= 1'b0;
        file_r[ptr_r]  <= '0;
        page_r[ptr_r]  <= '0;
      end
      if (cmd.apply_op && cmd.tag_step && tag_hit) begin
        case (rq_type_r)
          REQ_FETCH, REQ_PIN: begin
            if (pins_r[ptr_r] != PIN_MAX) pins_r[ptr_r] <= pins_r[ptr_r] + 8'd1;
          end
          REQ_UNPIN: begin
            if (pins_r[ptr_r] != 8'd0) pins_r[ptr_r] <= pins_r[ptr_r] - 8'd1;
          end
          REQ_DIRTY: dirty_r[ptr_r] <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.apply_op && cmd.vic_step && vic_hit) begin
        valid_r[lru_at] <= 1'b1;
        dirty_r[lru_at] <= 1'b0;
        file_r[lru_at]  <= rq_file_r;
        page_r[lru_at]  <= rq_page_r;
        pins_r[lru_at]  <= 8'd1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  `LPB_ASSERT_IMP(a_idx, clk, rst_n, cmd.apply_op, !(cmd.flush_step || cmd.drop_step), "apply during scan")
  `LPB_ASSERT_IMP(a_cap, clk, rst_n, 1'b1, nres_r <= CW'(MAX_RESULTS), "result cap exceeded")
  `LPB_ASSERT_NXT(a_clr, clk, rst_n, cmd.ptr_clr, ptr_r == '0, "pointer not cleared")
endmodule

// ----- sv/lru_page_buffer_pool_top.sv -----
// Top level of the LRU page buffer pool: controller plus datapath.
// Depends on lpbp_pkg, lpbp_ctrl and lpbp_datapath.
//
//  channel  handshake          payload
//  input    start / busy       in_req  (req_t)
//  result   out_valid strobe   out_rsp (rsp_t)
//
// A fetch hit runs the tag search, then the LRU move; a miss adds the victim
// walk over the LRU list between them. Pin, unpin and mark dirty run the tag
// search only; flush scans every frame, then ends, and clear then adds a pass
// that drops unpinned clean frames of the file. An unknown code is answered at
// decode. A flush writeback is held until its last bit is known.
// Reset is synchronous and needs no clearing pass. Results cannot be stalled.
`timescale 1ns / 1ps
module lru_page_buffer_pool_top #(
  parameter int unsigned POOL_FRAMES = lpbp_pkg::POOL_FRAMES_DEF,
  parameter int unsigned PAGE_BITS   = lpbp_pkg::PAGE_BITS_DEF,
  parameter int unsigned FILE_BITS   = lpbp_pkg::FILE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  lpbp_pkg::req_t in_req,
  output logic           out_valid,
  output lpbp_pkg::rsp_t out_rsp
);
  import lpbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpbp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  lpbp_datapath #(
    .POOL_FRAMES(POOL_FRAMES), .PAGE_BITS(PAGE_BITS), .FILE_BITS(FILE_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_rsp(out_rsp)
  );
endmodule
